// ===== design/assert_macros.svh =====
// Assertion macros shared by the ring point placer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define RPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define RPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpp_pkg.sv =====
// Package for the ring point placer: constants, register indexes, shared types.
package rpp_pkg;

  localparam int unsigned LENGTH_BITS_DEF  = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 20;

  localparam int unsigned REG_W   = 24;
  localparam int unsigned ARC_W   = 32;
  localparam int unsigned POS_W   = 25;
  localparam int unsigned ANGLE_W = 18;
  localparam int unsigned MAG_W   = 17;

  localparam logic [29:0]      GAIN_Q30    = 30'd652032874;
  localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629713;
  localparam logic [MAG_W-1:0] FULL_TURN   = 17'd92160;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_TOTAL  = 2'd1,
    REG_OFFSET = 2'd2,
    REG_SPARE  = 2'd3
  } reg_idx_t;

  // Request from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic              start;
    logic [ARC_W-1:0]  frac;
  } cord_req_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/rpp_div_step.sv =====
// One restoring division step: shift in a numerator bit and trial-subtract the divisor.
module rpp_div_step (
  input  logic [rpp_pkg::REG_W-1:0] rem_in,
  input  logic                      bit_in,
  input  logic [rpp_pkg::REG_W-1:0] divisor,
  output logic [rpp_pkg::REG_W-1:0] rem_out,
  output logic                      q_bit
);
  import rpp_pkg::*;

  logic [REG_W:0] trial;
  logic [REG_W:0] diff;

  assign trial   = {rem_in, bit_in};
  assign diff    = trial - {1'b0, divisor};
  assign q_bit   = (trial >= {1'b0, divisor});
  assign rem_out = q_bit ? diff[REG_W-1:0] : trial[REG_W-1:0];
endmodule

// ===== design/rpp_cordic.sv =====
// Iterative CORDIC rotation with quadrant fold, rounding and saturation of the position.
module rpp_cordic #(
  parameter int unsigned CORDIC_STEPS = rpp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rpp_pkg::cord_req_t               req,
  input  logic [rpp_pkg::REG_W-1:0]        radius,
  output logic                             done,
  output logic signed [rpp_pkg::POS_W-1:0] x_out,
  output logic signed [rpp_pkg::POS_W-1:0] y_out
);
  import rpp_pkg::*;

  localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned VW = 47;
  localparam int unsigned ZW = 33;
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  typedef enum logic [1:0] {C_IDLE, C_MUL, C_RUN, C_PACK} cstate_t;

  cstate_t              state_r;
  logic [ARC_W-1:0]     frac_r;
  logic [IW-1:0]        i_r;
  logic signed [VW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 done_r;
  logic signed [POS_W-1:0] x_out_r, y_out_r;

  logic [53:0]          gain_prod;
  logic [60:0]          ang_prod;
  logic signed [VW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [VW-1:0] c_val, s_val;

  function automatic logic signed [POS_W-1:0] pack_pos(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    logic signed [VW-1:0] r;
    logic signed [POS_W-1:0] res;
    t = v + VW'(524288);
    r = t >>> 20;
    if (r > VW'(16777215)) begin
      res = POS_W'(16777215);
    end else if (r < -VW'(16777215)) begin
      res = -POS_W'(16777215);
    end else begin
      res = r[POS_W-1:0];
    end
    return res;
  endfunction

  assign gain_prod = radius * GAIN_Q30;
  assign ang_prod  = frac_r[29:0] * HALF_PI_Q30;
  assign dx        = y_r >>> i_r;
  assign dy        = x_r >>> i_r;
  assign at        = $signed({3'b000, atan_lut(5'(i_r))});

  always_comb begin
    case (frac_r[31:30])
      2'd0: begin
        c_val = x_r;
        s_val = y_r;
      end
      2'd1: begin
        c_val = -y_r;
        s_val = x_r;
      end
      2'd2: begin
        c_val = -x_r;
        s_val = -y_r;
      end
      default: begin
        c_val = y_r;
        s_val = -x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      i_r     <= '0;
    end else begin
      done_r <= (state_r == C_PACK);
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            frac_r  <= req.frac;
            state_r <= C_MUL;
          end
        end
        C_MUL: begin
          x_r     <= $signed({3'b000, gain_prod[53:10]});
          y_r     <= '0;
          z_r     <= $signed({2'b00, ang_prod[60:30]});
          i_r     <= '0;
          state_r <= C_RUN;
        end
        C_RUN: begin
          if (!z_r[ZW-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == LAST_STEP) begin
            state_r <= C_PACK;
          end
        end
        C_PACK: begin
          x_out_r <= pack_pos(c_val);
          y_out_r <= pack_pos(s_val);
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign x_out = x_out_r;
  assign y_out = y_out_r;
endmodule

// ===== design/ring_point_placer.sv =====
// Ring point placer: arc bookkeeping, shared bit-serial divider sequencer and output word.
// Each accepted word passes setup, an angle division (only when the arc is inside the first turn
// and not a ring start), the modulo and fraction divisions, the CORDIC unit and the hold state.
// A new word is taken only once the previous one is in the output register: in_stall falls as
// out_valid rises, and an out_stall on an unread word keeps the block in the hold state.
// Reset (synchronous, rst_n low) sets radius 0, total 256, offset 0, clears the running arc.
module ring_point_placer #(
  parameter int unsigned LENGTH_BITS  = rpp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = rpp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rpp_pkg::REG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [LENGTH_BITS-1:0]             in_segment_length,
  input  logic                               in_first_of_ring,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rpp_pkg::POS_W-1:0]   out_x_pos,
  output logic signed [rpp_pkg::POS_W-1:0]   out_y_pos,
  output logic signed [rpp_pkg::ANGLE_W-1:0] out_rotate_angle
);
  import rpp_pkg::*;

  localparam int unsigned NUM_W = 41;
  localparam logic [5:0]  ANG_LAST = 6'(NUM_W - 1);
  localparam logic [5:0]  DIV_LAST = 6'(ARC_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_ANG, ST_MOD, ST_FRAC, ST_CORD, ST_HOLD
  } state_t;

  state_t                 state_r;
  logic [REG_W-1:0]       radius_r, total_r, offset_r;
  logic [LENGTH_BITS-1:0] prev_r;
  logic [ARC_W-1:0]       arc_sum_r, arc_r;
  logic                   first_r;
  logic [NUM_W-1:0]       num_r;
  logic [REG_W-1:0]       rem_r;
  logic [ARC_W-1:0]       q_r;
  logic [MAG_W-1:0]       mag_r;
  logic [5:0]             cnt_r;
  logic                   out_valid_r;
  logic signed [POS_W-1:0]   x_r, y_r;
  logic signed [ANGLE_W-1:0] angle_r;

  logic [REG_W-1:0]       tot;
  logic [LENGTH_BITS:0]   len_sum;
  logic [ARC_W:0]         arc_grow;
  logic [ARC_W-1:0]       arc_sat;
  logic [48:0]            ang_num;
  logic                   ds_bit;
  logic [REG_W-1:0]       ds_rem;
  logic                   ds_q;
  logic                   in_acc;
  logic                   out_free;
  cord_req_t              cord_req;
  logic                   cord_done;
  logic signed [POS_W-1:0] cord_x, cord_y;

  assign tot      = (total_r == '0) ? REG_W'(1) : total_r;
  assign len_sum  = {1'b0, in_segment_length} + {1'b0, prev_r};
  assign arc_grow = {1'b0, arc_sum_r} + (ARC_W + 1)'(len_sum[LENGTH_BITS:1]);
  assign arc_sat  = arc_grow[ARC_W] ? '1 : arc_grow[ARC_W-1:0];
  assign ang_num  = arc_sum_r * FULL_TURN;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The fraction pass feeds zeros; the other passes shift in numerator bits.
  assign ds_bit = (state_r == ST_FRAC) ? 1'b0 : num_r[NUM_W-1];

  rpp_div_step u_div_step (
    .rem_in  (rem_r),
    .bit_in  (ds_bit),
    .divisor (tot),
    .rem_out (ds_rem),
    .q_bit   (ds_q)
  );

  assign cord_req.start = (state_r == ST_FRAC) && (cnt_r == DIV_LAST);
  assign cord_req.frac  = {q_r[ARC_W-2:0], ds_q};

  rpp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cord_req),
    .radius (radius_r),
    .done   (cord_done),
    .x_out  (cord_x),
    .y_out  (cord_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= '0;
      total_r     <= REG_W'(256);
      offset_r    <= '0;
      prev_r      <= '0;
      arc_sum_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS: radius_r <= cfg_data;
          REG_TOTAL:  total_r  <= cfg_data;
          REG_OFFSET: offset_r <= cfg_data;
          default: ;
        endcase
      end

      // The hold state reloads the output word itself.
      if (out_valid_r && !out_stall && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            prev_r  <= in_segment_length;
            first_r <= in_first_of_ring;
            if (in_first_of_ring) begin
              arc_sum_r <= '0;
              arc_r     <= ARC_W'(offset_r);
            end else begin
              arc_sum_r <= arc_sat;
              arc_r     <= arc_sat;
            end
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rem_r <= '0;
          cnt_r <= '0;
          if (first_r || (arc_sum_r >= ARC_W'(tot))) begin
            mag_r   <= first_r ? '0 : FULL_TURN;
            num_r   <= {arc_r, (NUM_W - ARC_W)'(0)};
            state_r <= ST_MOD;
          end else begin
            // Arc below one turn, so the product fits the numerator register.
            num_r   <= ang_num[NUM_W-1:0];
            state_r <= ST_ANG;
          end
        end
        ST_ANG: begin
          q_r <= {q_r[ARC_W-2:0], ds_q};
          if (cnt_r == ANG_LAST) begin
            mag_r   <= {q_r[MAG_W-2:0], ds_q};
            rem_r   <= '0;
            cnt_r   <= '0;
            num_r   <= {arc_r, (NUM_W - ARC_W)'(0)};
            state_r <= ST_MOD;
          end else begin
            rem_r <= ds_rem;
            num_r <= num_r << 1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_MOD: begin
          rem_r <= ds_rem;
          num_r <= num_r << 1;
          if (cnt_r == DIV_LAST) begin
            cnt_r   <= '0;
            state_r <= ST_FRAC;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_FRAC: begin
          rem_r <= ds_rem;
          q_r   <= {q_r[ARC_W-2:0], ds_q};
          if (cnt_r == DIV_LAST) begin
            cnt_r   <= '0;
            state_r <= ST_CORD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_CORD: begin
          if (cord_done) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            x_r         <= cord_x;
            y_r         <= cord_y;
            angle_r     <= ANGLE_W'(-$signed({2'b00, mag_r}));
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_x_pos        = x_r;
  assign out_y_pos        = y_r;
  assign out_rotate_angle = angle_r;

  `include "assert_macros.svh"

  `RPP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")
  `RPP_ASSERT_NOW(a_cordic_done_when_waiting, cord_done, state_r == ST_CORD, "CORDIC finished outside its wait state")
  `RPP_ASSERT_NOW(a_angle_range, out_valid, (out_rotate_angle <= 0) && (out_rotate_angle >= -92160), "rotation angle out of range")
endmodule

// ===== tb/ring_point_placer_checker.sv =====
// Checker for the ring point placer: predicts each placement and compares the output words.
module ring_point_placer_checker
  import rpp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [23:0]               in_segment_length,
  input  logic                      in_first_of_ring,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [POS_W-1:0]   out_x_pos,
  input  logic signed [POS_W-1:0]   out_y_pos,
  input  logic signed [ANGLE_W-1:0] out_rotate_angle,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [ANGLE_W-1:0] angle;
  } placement_t;

  localparam int ROTATIONS = 20;
  localparam longint ARC_MAX = 64'hFFFF_FFFF;

  // Arctangent of 2^-i in radians, 30 fraction bits.
  const longint atan_rad[ROTATIONS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048
  };

  placement_t placement_q[$];
  longint unsigned radius_r, total_r, offset_r, prev_len, arc_acc;

  function automatic logic signed [POS_W-1:0] round_pos(longint v);
    longint r;
    r = (v + (64'sd1 <<< 19)) >>> 20;
    if (r > 16777215) r = 16777215;
    if (r < -16777215) r = -16777215;
    return r[POS_W-1:0];
  endfunction

  // Point on the ring at the given arc: quadrant from the turn fraction, CORDIC for the rest.
  function automatic void place_on_ring(longint unsigned arc, longint unsigned total,
                                        output logic signed [POS_W-1:0] xo,
                                        output logic signed [POS_W-1:0] yo);
    longint unsigned frac;
    longint x, y, z, dx, dy, c, s;
    logic [1:0] quad;
    frac = ((arc % total) << 32) / total;
    quad = frac[31:30];
    z = longint'(((frac & 64'h3FFF_FFFF) * 64'd1686629713) >> 30);
    x = longint'((radius_r * 64'd652032874) >> 10);
    y = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_rad[i];
      end else begin
        x += dx; y -= dy; z += atan_rad[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    xo = round_pos(c);
    yo = round_pos(s);
  endfunction

  function automatic placement_t predict_placement(logic [23:0] seg, logic first);
    placement_t p;
    longint unsigned total, mag;
    total = (total_r == 0) ? 1 : total_r;
    if (first) begin
      arc_acc = 0;
      prev_len = seg;
      place_on_ring(offset_r, total, p.x, p.y);
      p.angle = '0;
    end else begin
      arc_acc += (seg + prev_len) >> 1;
      if (arc_acc > ARC_MAX) arc_acc = ARC_MAX;
      prev_len = seg;
      place_on_ring(arc_acc, total, p.x, p.y);
      mag = (arc_acc >= total) ? 92160 : (92160 * arc_acc) / total;
      p.angle = ANGLE_W'(-longint'(mag));
    end
    return p;
  endfunction

  always @(posedge clk) begin
    placement_t fresh, want;
    if (!rst_n) begin
      radius_r = 0; total_r = 256; offset_r = 0;
      prev_len = 0; arc_acc = 0;
      placement_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RADIUS: radius_r = cfg_data;
          REG_TOTAL:  total_r = cfg_data;
          REG_OFFSET: offset_r = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fresh = predict_placement(in_segment_length, in_first_of_ring);
        placement_q = {placement_q, fresh};
      end
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          $error("output word with no expectation waiting");
          errors++;
        end else begin
          want = placement_q.pop_front();
          if (out_x_pos !== want.x) begin
            $error("x_pos: expected %0d, got %0d", want.x, out_x_pos);
            errors++;
          end
          if (out_y_pos !== want.y) begin
            $error("y_pos: expected %0d, got %0d", want.y, out_y_pos);
            errors++;
          end
          if (out_rotate_angle !== want.angle) begin
            $error("rotate_angle: expected %0d, got %0d", want.angle, out_rotate_angle);
            errors++;
          end
        end
      end
    end
    pending = placement_q.size();
  end

endmodule

// ===== tb/ring_point_placer_test.sv =====
// Top of the ring point placer testbench: clock, reset, stimulus, stalls and verdict.
module ring_point_placer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpp_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [REG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [23:0]               in_segment_length = '0;
  logic                      in_first_of_ring = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [POS_W-1:0]   out_x_pos, out_y_pos;
  logic signed [ANGLE_W-1:0] out_rotate_angle;
  int errors, pending;
  int outs_seen = 0;
  logic [23:0] cur_total = 24'd256;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ring_point_placer u_top (.*);

  ring_point_placer_checker u_checker (.*);

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_TOTAL) cur_total = value;
  endtask

  task automatic send_segment(logic [23:0] seg, logic first, bit gaps);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    in_segment_length = seg;
    in_first_of_ring = first;
    do @(posedge clk); while (in_stall);
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Drop valid before waiting so the last word is not taken a second time.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random segments: full range, up to half the ring total, or the extremes.
  task automatic random_rings(int count, int first_pct, int max_pct);
    logic [23:0] seg;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < max_pct) seg = 24'hFFFFFF;
      else if (pick < max_pct + 40) seg = 24'($urandom_range(0, 24'hFFFFFF));
      else if (pick < max_pct + 45) seg = 24'h0;
      else seg = 24'($urandom_range(0, (cur_total < 2) ? 2 : cur_total / 2));
      send_segment(seg, $urandom_range(0, 99) < first_pct, 1'b1);
    end
  endtask

  always @(posedge clk)
    if (out_valid && !out_stall) outs_seen <= outs_seen + 1;

  // Receiver: short random stalls, plus one long hold-off so the block backs up.
  initial begin
    int g;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && outs_seen >= 30) begin
        held = 1;
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        g = rand_gap();
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles with no word accepted on either channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("ring_point_placer_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // No ring start since reset, then a jump far past one turn.
    send_segment(24'h000100, 1'b0, 1'b0);
    send_segment(24'hFFFFFF, 1'b0, 1'b0);
    send_segment(24'h000000, 1'b0, 1'b1);
    drain();
    write_reg(REG_RADIUS, 24'hFFFFFF);
    // Quarter-turn steps walk through all four quadrants.
    send_segment(24'h000040, 1'b1, 1'b0);
    repeat (5) send_segment(24'h000040, 1'b0, 1'b0);
    send_segment(24'h000020, 1'b0, 1'b1);
    send_segment(24'hFFFFFF, 1'b1, 1'b1);
    send_segment(24'h000000, 1'b0, 1'b1);
    drain();
    // A zero total behaves as a total of one.
    write_reg(REG_TOTAL, 24'h000000);
    write_reg(REG_OFFSET, 24'hFFFFFF);
    send_segment(24'h000005, 1'b1, 1'b0);
    send_segment(24'h000003, 1'b0, 1'b0);
    send_segment(24'hFFFFFF, 1'b0, 1'b1);
    drain();
    write_reg(REG_TOTAL, 24'hFFFFFF);
    write_reg(REG_OFFSET, 24'h7FFFFF);
    write_reg(REG_RADIUS, 24'h000001);
    send_segment(24'h000000, 1'b1, 1'b0);
    send_segment(24'h555555, 1'b0, 1'b0);
    send_segment(24'hAAAAAA, 1'b0, 1'b0);
    drain();

    write_reg(REG_RADIUS, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_TOTAL, 24'($urandom_range(1, 24'hFFFFFF)));
    write_reg(REG_OFFSET, 24'($urandom_range(0, 24'hFFFFFF)));
    random_rings(150, 12, 5);
    drain();

    // Long ring of large segments so the running arc saturates.
    write_reg(REG_RADIUS, 24'hFFFFFF);
    write_reg(REG_TOTAL, 24'hFFFFFF);
    send_segment(24'hFFFFFF, 1'b1, 1'b1);
    random_rings(280, 0, 85);
    drain();

    write_reg(REG_RADIUS, 24'($urandom_range(0, 24'h00FFFF)));
    write_reg(REG_TOTAL, 24'($urandom_range(1, 24'h00FFFF)));
    write_reg(REG_OFFSET, 24'($urandom_range(0, 24'h00FFFF)));
    random_rings(150, 15, 5);
    drain();

    write_reg(REG_RADIUS, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_TOTAL, 24'($urandom_range(1, 16)));
    write_reg(REG_OFFSET, 24'($urandom_range(0, 24'hFFFFFF)));
    random_rings(120, 10, 5);
    drain();

    if (errors == 0 && pending == 0)
      $display("ring_point_placer_test: PASS");
    else
      $display("ring_point_placer_test: FAIL");
    $finish;
  end

endmodule
